// File: src/dpfc_pkg.sv
`default_nettype none

package dpfc_pkg;

	localparam int TRIAL_LIMIT = 4096;
	localparam int VALUE_W = 24;
	localparam int COUNT_W = 4;
	localparam int MAX_FACTORS = 8;

	// candidate divisor must reach TRIAL_LIMIT itself
	localparam int CAND_W = $clog2(TRIAL_LIMIT) + 1;
	localparam int SQ_W = 2 * CAND_W;

	// prime map held as words of 16 flags
	localparam int WORD_BITS = 16;
	localparam int OFF_W = $clog2(WORD_BITS);
	localparam int IDX_W = CAND_W - OFF_W;
	localparam int MAP_WORDS = (TRIAL_LIMIT + WORD_BITS - 1) / WORD_BITS;
	localparam int MAP_BITS = MAP_WORDS * WORD_BITS;

	// divider retires this many quotient bits per cycle
	localparam int DIV_BITS_PER_CYCLE = 8;
	localparam int DIV_CYCLES = (VALUE_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
	localparam int DIV_CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CAND_W-1:0] cand_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [OFF_W-1:0] off_t;

	typedef struct packed {
		logic start;
		value_t dividend;
		cand_t divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		value_t quotient;
		cand_t remainder;
	} div_rsp_t;

	// sieve, evaluated at elaboration; bit i set when i is prime
	function automatic logic [MAP_BITS-1:0] build_prime_map();
		logic [MAP_BITS-1:0] m;
		int i;
		int j;
		m = '0;
		for (i = 2; i < TRIAL_LIMIT; i++) begin
			m[i] = 1'b1;
		end
		for (i = 2; i * i < TRIAL_LIMIT; i++) begin
			if (m[i]) begin
				for (j = i * i; j < TRIAL_LIMIT; j += i) begin
					m[j] = 1'b0;
				end
			end
		end
		return m;
	endfunction

	localparam logic [MAP_BITS-1:0] PRIME_MAP = build_prime_map();

	function automatic word_t map_word(idx_t idx);
		word_t w;
		w = '0;
		if (int'(idx) < MAP_WORDS) begin
			w = PRIME_MAP[int'(idx) * WORD_BITS +: WORD_BITS];
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// File: src/dpfc_if.sv
`default_nettype none

interface dpfc_req_if;
	logic valid;
	logic ready;
	logic [dpfc_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface dpfc_rsp_if;
	logic valid;
	logic ready;
	logic [dpfc_pkg::COUNT_W-1:0] factor_count;

	modport source (output valid, output factor_count, input ready);
	modport sink (input valid, input factor_count, output ready);
endinterface

`default_nettype wire

// File: src/dpfc_div.sv
`default_nettype none

// Restoring divider, several quotient bits per cycle.
module dpfc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dpfc_pkg::div_req_t req,
	output dpfc_pkg::div_rsp_t rsp
);
	import dpfc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	value_t               work_q;
	cand_t                rem_q;
	cand_t                div_q;

	value_t               work_nx;
	cand_t                rem_nx;
	logic [CAND_W:0]      trial;

	// dividend shifts out of the top of work, quotient bits enter at the bottom
	always_comb begin
		work_nx = work_q;
		rem_nx = rem_q;
		trial = '0;
		for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
			trial = {rem_nx, work_nx[VALUE_W-1]};
			work_nx = {work_nx[VALUE_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
				work_nx[0] = 1'b1;
			end
			rem_nx = trial[CAND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= work_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = work_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// File: src/distinct_prime_factor_counter.sv
`default_nettype none

// Work per value: no division for values 0 and 1; otherwise one division per prime tried up to
//   sqrt of what is left of the value, one more per extra division by a found factor, and one
//   scan step per 16-flag map word skipped or jump in a word, over the 4096-entry prime map.
// Only one value is in work at a time; the divider sets the pace.
// Reset: arst_n asynchronous active low; returns to idle, drops any pending result.
// The prime map is a constant table, no clearing pass is needed after reset.
module distinct_prime_factor_counter (
	input  logic clk,
	input  logic arst_n,
	dpfc_req_if.sink   req,
	dpfc_rsp_if.source rsp
);
	import dpfc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	value_t v_q;        // value still to be factored
	cand_t  d_q;        // current trial divisor
	count_t cnt_q;      // distinct primes found so far
	logic   hit_q;      // d_q already counted for this value
	logic   out_valid_q;
	count_t out_count_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	idx_t            idx;
	off_t            off;
	word_t           word;
	word_t           masked;
	logic            found;
	off_t            pos;
	logic [SQ_W-1:0] sq;
	logic            finish;
	logic            prime_here;
	cand_t           skip_d;
	logic            div_exact;

	// Shared divider: every divisibility test and every division-out goes through it.
	dpfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Scan: one map word per cycle, to the lowest prime >= d_q in it, else the next word.
	assign idx = d_q[CAND_W-1:OFF_W];
	assign off = d_q[OFF_W-1:0];
	assign word = map_word(idx);
	assign masked = word & (word_t'({WORD_BITS{1'b1}}) << off);
	assign found = |masked;

	always_comb begin
		pos = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (masked[k]) begin
				pos = off_t'(k);
			end
		end
	end

	assign prime_here = found && (pos == off);
	assign skip_d = found ? {idx, pos} : {idx + idx_t'(1), off_t'(0)};

	// Stop once d*d exceeds what is left: whatever remains above 1 is prime.
	// Zero and one both end here at once, the remainder term adds nothing for them.
	assign sq = SQ_W'(d_q) * SQ_W'(d_q);
	assign finish = (v_q <= value_t'(1)) || (sq > SQ_W'(v_q)) ||
		(d_q >= cand_t'(TRIAL_LIMIT));

	assign div_exact = div_rsp.done && (div_rsp.remainder == '0);

	// A division by a known factor chains straight into the next one on the quotient.
	assign div_req.start = ((state_q == ST_SCAN) && !finish && prime_here) ||
		((state_q == ST_DIV) && div_exact);
	assign div_req.dividend = (state_q == ST_DIV) ? div_rsp.quotient : v_q;
	assign div_req.divisor = d_q;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.factor_count = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_q <= '0;
			d_q <= '0;
			cnt_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_count_q <= '0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						v_q <= req.value;
						d_q <= cand_t'(2);
						cnt_q <= '0;
						hit_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						cnt_q <= cnt_q + count_t'(v_q > value_t'(1));
						state_q <= ST_DONE;
					end else if (prime_here) begin
						state_q <= ST_DIV;
					end else begin
						d_q <= skip_d;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (div_exact) begin
							if (!hit_q) begin
								cnt_q <= cnt_q + count_t'(1);
							end
							hit_q <= 1'b1;
							v_q <= div_rsp.quotient;
						end else begin
							hit_q <= 1'b0;
							d_q <= d_q + cand_t'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_DONE: begin
					// output register frees up or is taken this cycle
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_count_q <= cnt_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_div_on_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> word[off])
		else $error("divider working on a non-prime candidate");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_rsp.busy && !div_rsp.done)
		else $error("divider active while idle");

	a_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == ST_SCAN || state_q == ST_DIV))
		else $error("division started outside the search");

	a_cand_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DIV) |-> (d_q >= cand_t'(2)))
		else $error("trial divisor below two");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_count_q <= count_t'(MAX_FACTORS)))
		else $error("factor count out of range");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dpfc_pkg::*;

	// A result trails its transfer longest for two prime factors just below
	// the trial limit, so the watchdog and the drain at the end leave room
	// for that plus both sides' longest waits.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 4000;
	localparam int MAX_WAIT = 13;
	localparam int REPORT_LIMIT = 10;
	localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_W) - 1;

	// Corner values: zero, one, small primes and powers, the all-ones and
	// alternating patterns, the most distinct prime factors a 24-bit value can have,
	// the largest primes below the trial limit squared and multiplied together,
	// and primes above the trial limit that only the remainder rule catches.
	localparam value_t CORNER_VALUES [20] = '{
		24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd6,
		24'd4093, 24'd4095, 24'd4096, 24'd4099, 24'd8186,
		24'd9699690,       // 2*3*5*7*11*13*17*19
		24'd8388608,       // 2^23
		24'd16752649,      // 4093^2
		24'd16744463,      // 4091*4093
		24'd16777207,      // 4093*4099
		24'd16777213,      // prime
		24'hFFFFFF, 24'hAAAAAA, 24'h555555
	};

	typedef struct {
		value_t value;
		count_t count;
	} pending_count_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dpfc_req_if req_ch ();
	dpfc_rsp_if rsp_ch ();

	distinct_prime_factor_counter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	// own sieve for the predictor and for building stimulus
	bit is_prime [TRIAL_LIMIT];
	int unsigned prime_list [$];

	pending_count_t expected_counts [$];
	int fault_count = 0;
	int idle_cycles = 0;

	// when set, that side never waits between transfers
	bit feed_quiet = 1'b0;
	bit sink_quiet = 1'b0;

	// Trial division over the primes below the limit, dividing each found
	// prime out completely and stopping once the value is down to one.
	// Whatever is left above one counts as a single extra prime.
	// Zero has no search at all and answers zero.
	function automatic count_t count_distinct_primes(input value_t v);
		int unsigned rest;
		int unsigned d;
		int unsigned n;
		rest = 32'(v);
		n = 0;
		if (rest == 0)
			return '0;
		for (d = 2; d < TRIAL_LIMIT && rest != 1; d++) begin
			if (is_prime[d] && rest % d == 0) begin
				n++;
				while (rest % d == 0)
					rest = rest / d;
			end
		end
		if (rest != 1)
			n++;
		return count_t'(n);
	endfunction

	function automatic int draw_wait(input bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Products of random primes with random powers. Mostly from the first
	// 25 primes at most so that many distinct factors fit, sometimes from
	// the whole prime list.
	function automatic value_t draw_factor_product();
		longint unsigned prod;
		longint unsigned p;
		int unsigned reach;
		int unsigned n;
		int k;
		prod = 1;
		n = $urandom_range(1, MAX_FACTORS);
		if ($urandom_range(0, 3) == 0)
			reach = prime_list.size();
		else
			reach = $urandom_range(1, 25);
		for (k = 0; k < n; k++) begin
			p = 64'(prime_list[$urandom_range(0, reach - 1)]);
			repeat ($urandom_range(1, 3)) begin
				if (prod * p <= VALUE_MAX)
					prod = prod * p;
			end
		end
		return value_t'(prod);
	endfunction

	// Mixed widths. Full-width values flip every input bit; products of two
	// primes near the top of the list force the longest walk, so they stay rare.
	function automatic value_t draw_wide_value();
		int unsigned sel;
		int unsigned bits;
		int unsigned top;
		longint unsigned p;
		longint unsigned q;
		longint unsigned prod;
		sel = $urandom_range(0, 99);
		top = prime_list.size();
		if (sel < 30)
			return value_t'($urandom);
		if (sel < 60) begin
			bits = $urandom_range(1, VALUE_W);
			return value_t'($urandom) >> (VALUE_W - bits);
		end
		if (sel < 85)
			return value_t'($urandom_range(0, 65535));
		if (sel < 92) begin
			p = 64'(prime_list[$urandom_range(top - 40, top - 1)]);
			q = 64'(prime_list[$urandom_range(top - 40, top - 1)]);
			return value_t'(p * q);
		end
		// prime power, possibly times a prime above the trial limit
		p = 64'(prime_list[$urandom_range(0, top - 1)]);
		prod = p;
		while (prod * p <= VALUE_MAX && $urandom_range(0, 3) != 0)
			prod = prod * p;
		if ($urandom_range(0, 1) == 0 && prod * 4099 <= VALUE_MAX)
			prod = prod * 4099;
		return value_t'(prod);
	endfunction

	// Offer one value after a random gap and hold it until the transfer.
	// Valid is left high on return; the next call or the end of the run
	// decides whether it drops, so it never gets two assignments in one step.
	task automatic send_value(input value_t v);
		int gap;
		pending_count_t entry;
		gap = draw_wait(feed_quiet);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.value <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		entry.value = v;
		entry.count = count_distinct_primes(v);
		expected_counts.insert(expected_counts.size(), entry);
	endtask

	task automatic test_corner_values();
		int k;
		for (k = 0; k < $size(CORNER_VALUES); k++)
			send_value(CORNER_VALUES[k]);
	endtask

	task automatic test_factor_products();
		int k;
		for (k = 0; k < 400; k++) begin
			// switch the idling pattern every 50 transfers
			if (k % 50 == 0) begin
				feed_quiet = ($urandom_range(0, 3) == 0);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			send_value(draw_factor_product());
		end
	endtask

	task automatic test_wide_values();
		int k;
		for (k = 0; k < 400; k++) begin
			if (k % 50 == 0) begin
				feed_quiet = ($urandom_range(0, 3) == 0);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			send_value(draw_wide_value());
		end
	endtask

	// no gaps on either side: neither side waits between transfers
	task automatic test_back_to_back();
		int k;
		feed_quiet = 1'b1;
		sink_quiet = 1'b1;
		for (k = 0; k < 200; k++) begin
			if ($urandom_range(0, 1) == 0)
				send_value(draw_factor_product());
			else
				send_value(draw_wide_value());
		end
		feed_quiet = 1'b0;
		sink_quiet = 1'b0;
	endtask

	initial begin
		int i;
		int m;
		req_ch.valid <= 1'b0;
		req_ch.value <= '0;

		for (i = 0; i < TRIAL_LIMIT; i++)
			is_prime[i] = (i >= 2);
		for (i = 2; i < TRIAL_LIMIT; i++) begin
			if (is_prime[i]) begin
				prime_list.insert(prime_list.size(), unsigned'(i));
				for (m = i + i; m < TRIAL_LIMIT; m += i)
					is_prime[m] = 1'b0;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_factor_products();
		test_wide_values();
		test_back_to_back();
		req_ch.valid <= 1'b0;

		// let every pending result arrive, then watch for strays
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stall before each transfer, then compare with the
	// oldest pending prediction. Values are read just after the edge, before
	// the block's own updates land, so they are the ones that were transferred.
	initial begin
		int stall;
		pending_count_t entry;
		rsp_ch.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			stall = draw_wait(sink_quiet);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
			if (expected_counts.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result: factor_count %0d with nothing pending",
						rsp_ch.factor_count);
			end else begin
				entry = expected_counts.pop_front();
				if (rsp_ch.factor_count !== entry.count) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("value %0d: factor_count expected %0d, got %0d",
							entry.value, entry.count, rsp_ch.factor_count);
				end
			end
		end
	end

	// Watchdog: cycles with no transfer on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
